### src/acfs_pkg.sv
// ----------------------------------------------------------------------------
// acfs_pkg: shared types and constants for the audio chunk fade splicer
// Field widths, register indexes, the job record passed from front to back,
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package acfs_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int FADE_W     = 12;  // fade_len register
  localparam int CHAN_W     = 4;   // chan_count register
  localparam int LEN_W      = 16;  // chunk_len / frame position
  localparam int ZRUN_W     = 15;  // zero_run result field
  localparam int WGT_W      = 17;  // weight, 65536 means 1.0
  localparam int WGT_FRAC   = 16;
  localparam int DIV_STEPS  = 17;  // one quotient bit per step
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int USER_W     = 2;   // {chunk_final, chunk_start}
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = CFG_IDX_W'(1);

  localparam int USER_START_BIT = 0;
  localparam int USER_FINAL_BIT = 1;

  // Work for one item: up to two weight divisions plus the zero-run count.
  typedef struct packed {
    logic                 in_div;
    logic [FADE_W-1:0]    in_num;
    logic [FADE_W-1:0]    in_den;
    logic                 out_div;
    logic [FADE_W-1:0]    out_num;
    logic [FADE_W-1:0]    out_den;
    logic [ZRUN_W-1:0]    zrun;
  } acfs_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL_IN,
    BK_MUL_OUT,
    BK_HOLD
  } acfs_bk_state_t;

endpackage

### src/acfs_front.sv
// ----------------------------------------------------------------------------
// acfs_front: item intake and classification
// Holds the configuration and chunk tracking state, decides which fade
// windows an item falls in and hands a job to the queue.
// ----------------------------------------------------------------------------
module acfs_front import acfs_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic                   chunk_start,
  input  logic [LEN_W-1:0]       chunk_len,
  input  logic                   chunk_final,
  output logic [SAMPLE_BITS-1:0] job_sample,
  output acfs_job_t              job
);

  localparam int CH_EW = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W = (CH_EW > CHAN_W) ? CH_EW : CHAN_W;
  localparam int CP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [FADE_W-1:0] fade_len_r;
  logic [CHAN_W-1:0] chan_count_r;
  logic [LEN_W-1:0]  frame_pos_r, frame_pos_nxt;
  logic [CP_W-1:0]   chan_pos_r, chan_pos_nxt;
  logic [LEN_W-1:0]  cur_len_r;
  logic              cur_final_r;
  logic              first_chunk_r;
  logic              in_first_r;

  logic [CNT_W-1:0]  ch_eff, cc_ext;
  logic [LEN_W-1:0]  fp, len;
  logic [CP_W-1:0]   cp;
  logic              opens, final_c, active, fin, fout;
  logic [FADE_W-1:0] win_in, win_out, idx_out;
  logic [LEN_W:0]    end_sum, over;
  logic [FADE_W+CNT_W-1:0] zprod;

  always_comb begin
    cc_ext = CNT_W'(chan_count_r);
    if (chan_count_r == '0) begin
      ch_eff = CNT_W'(1);
    end else if (cc_ext > CNT_W'(MAX_CHANNELS)) begin
      ch_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      ch_eff = cc_ext;
    end
  end

  // Chunk header takes effect on the item that carries it.
  always_comb begin
    fp      = chunk_start ? '0 : frame_pos_r;
    cp      = chunk_start ? '0 : chan_pos_r;
    len     = chunk_start ? chunk_len : cur_len_r;
    opens   = chunk_start ? first_chunk_r : in_first_r;
    final_c = chunk_start ? chunk_final : cur_final_r;

    active  = fp < len;
    win_in  = ({{(LEN_W-FADE_W){1'b0}}, fade_len_r} < len) ? fade_len_r : len[FADE_W-1:0];
    win_out = opens ? win_in : fade_len_r;
    fin     = active && !opens && ({{(LEN_W-FADE_W){1'b0}}, win_in} > fp);
    end_sum = {1'b0, fp} + (LEN_W+1)'(win_out);
    fout    = active && !final_c && (end_sum >= {1'b0, len});
    over    = end_sum - {1'b0, len};
    idx_out = over[FADE_W-1:0];
    zprod   = fade_len_r * ch_eff;
  end

  always_comb begin
    job         = '0;
    job_sample  = sample_in;
    // a one-frame fade-in window mutes the sample
    if (fin && win_in <= FADE_W'(1)) begin
      job_sample = '0;
    end else if (fin) begin
      job.in_div = 1'b1;
      job.in_num = fp[FADE_W-1:0];
      job.in_den = win_in - FADE_W'(1);
    end
    if (fout && win_out > FADE_W'(1)) begin
      job.out_div = 1'b1;
      job.out_den = win_out - FADE_W'(1);
      job.out_num = win_out - FADE_W'(1) - idx_out;
    end
    if (chunk_start && !first_chunk_r) begin
      job.zrun = zprod[ZRUN_W-1:0];
    end
  end

  always_comb begin
    if (CNT_W'(cp) + CNT_W'(1) >= ch_eff) begin
      chan_pos_nxt  = '0;
      frame_pos_nxt = (fp == {LEN_W{1'b1}}) ? fp : fp + LEN_W'(1);
    end else begin
      chan_pos_nxt  = cp + CP_W'(1);
      frame_pos_nxt = fp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_len_r   <= '0;
      chan_count_r <= CHAN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FADE_LEN:   fade_len_r   <= cfg_data[FADE_W-1:0];
        REG_CHAN_COUNT: chan_count_r <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r   <= '0;
      chan_pos_r    <= '0;
      cur_len_r     <= '0;
      cur_final_r   <= 1'b0;
      first_chunk_r <= 1'b1;
      in_first_r    <= 1'b1;
    end else if (accept) begin
      frame_pos_r <= frame_pos_nxt;
      chan_pos_r  <= chan_pos_nxt;
      if (chunk_start) begin
        cur_len_r     <= chunk_len;
        cur_final_r   <= chunk_final;
        first_chunk_r <= chunk_final;
        in_first_r    <= first_chunk_r;
      end
    end
  end

endmodule

### src/acfs_queue.sv
// ----------------------------------------------------------------------------
// acfs_queue: short job queue between front and back
// Small register FIFO so the intake and the arithmetic stall independently.
// ----------------------------------------------------------------------------
module acfs_queue import acfs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### src/acfs_back.sv
// ----------------------------------------------------------------------------
// acfs_back: weight division and sample scaling
// Two restoring dividers produce the fade-in and fade-out weights side by
// side, then the sample is scaled by each in turn and parked in the output
// register.
// ----------------------------------------------------------------------------
module acfs_back import acfs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  input  acfs_job_t              q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic [ZRUN_W-1:0]      out_zrun
);

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int PROD_W = SAMPLE_BITS + WGT_W + 1;

  acfs_bk_state_t st_r, st_nxt;

  logic [SAMPLE_BITS-1:0] sample_r;
  acfs_job_t              job_r;
  logic [FADE_W-1:0]      rem_in_r, rem_out_r;
  logic [WGT_W-1:0]       q_in_r, q_out_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [ZRUN_W-1:0]      out_zrun_r;

  logic                   slot_free, load_out, last_step;
  logic [FADE_W:0]        st_in, st_out;
  logic [WGT_W-1:0]       wgt;
  logic signed [PROD_W-1:0] prod, prod_adj, prod_sh;

  // One restoring step; the first step compares the numerator unshifted,
  // which yields the integer bit of the weight.
  function automatic logic [FADE_W:0] div_step(input logic [FADE_W-1:0] rem,
                                               input logic [FADE_W-1:0] den,
                                               input logic first);
    logic [FADE_W:0] t;
    logic [FADE_W:0] d;
    t = first ? {1'b0, rem} : {rem, 1'b0};
    d = {1'b0, den};
    if (t >= d) begin
      t = t - d;
      return {1'b1, t[FADE_W-1:0]};
    end
    return {1'b0, t[FADE_W-1:0]};
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign st_in     = div_step(rem_in_r, job_r.in_den, step_r == '0);
  assign st_out    = div_step(rem_out_r, job_r.out_den, step_r == '0);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:    if (!q_empty) st_nxt = BK_DIV;
      BK_DIV:     if (last_step) st_nxt = BK_MUL_IN;
      BK_MUL_IN:  st_nxt = BK_MUL_OUT;
      BK_MUL_OUT: st_nxt = BK_HOLD;
      BK_HOLD:    if (slot_free) st_nxt = BK_IDLE;
      default:    st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      BK_IDLE: q_pop    = !q_empty;
      BK_HOLD: load_out = slot_free;
      default: ;
    endcase
  end

  // Scale by the weight of the current pass, truncating toward zero.
  always_comb begin
    if (st_r == BK_MUL_IN) begin
      wgt = job_r.in_div ? q_in_r : WGT_W'(1 << WGT_FRAC);
    end else begin
      wgt = job_r.out_div ? q_out_r : WGT_W'(1 << WGT_FRAC);
    end
    prod     = $signed(sample_r) * $signed({1'b0, wgt});
    prod_adj = prod[PROD_W-1] ? prod + PROD_W'((1 << WGT_FRAC) - 1) : prod;
    prod_sh  = prod_adj >>> WGT_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r  <= q_sample;
      job_r     <= q_job;
      rem_in_r  <= q_job.in_num;
      rem_out_r <= q_job.out_num;
      step_r    <= '0;
    end else if (st_r == BK_DIV) begin
      rem_in_r  <= st_in[FADE_W-1:0];
      rem_out_r <= st_out[FADE_W-1:0];
      q_in_r    <= {q_in_r[WGT_W-2:0], st_in[FADE_W]};
      q_out_r   <= {q_out_r[WGT_W-2:0], st_out[FADE_W]};
      step_r    <= step_r + STEP_W'(1);
    end else if (st_r == BK_MUL_IN || st_r == BK_MUL_OUT) begin
      sample_r  <= prod_sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= sample_r;
      out_zrun_r   <= job_r.zrun;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_zrun   = out_zrun_r;

endmodule

### src/audio_chunk_fade_splicer_top.sv
// ----------------------------------------------------------------------------
// audio_chunk_fade_splicer_top: audio chunk splicer with linear fades
// Weights each interleaved sample for chunk fade-out / fade-in and reports
// the zero-sample run that precedes each later chunk.
// ----------------------------------------------------------------------------
// One sample in gives one sample out. In the back end each item is loaded,
// run through the weight division (a restoring divider producing one
// quotient bit per cycle, with fade-in and fade-out weights computed in
// parallel), scaled in two multiply passes and moved to the output register
// once it is free. The front end keeps accepting items while the two-entry
// queue has room, so up to four items can be in flight. Configure fade_len
// and chan_count only while the block is idle; cfg_ready is always high.
module audio_chunk_fade_splicer_top import acfs_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_in, chunk_len
  input  logic [((SAMPLE_BITS+LEN_W+7)/8)*8-1:0]  in_tdata,
  // chunk_start, chunk_final
  input  logic [USER_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sample_out, zero_run, zero pad
  output logic [((SAMPLE_BITS+ZRUN_W+7)/8)*8-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_DW = ((SAMPLE_BITS + ZRUN_W + 7) / 8) * 8;
  localparam int JOB_W  = $bits(acfs_job_t);
  localparam int Q_W    = SAMPLE_BITS + JOB_W;

  logic                   accept, q_full, q_empty, q_pop;
  logic [SAMPLE_BITS-1:0] f_sample, b_sample, out_sample;
  acfs_job_t              f_job, b_job;
  logic [Q_W-1:0]         q_out;
  logic [ZRUN_W-1:0]      out_zrun;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  acfs_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .sample_in   (in_tdata[SAMPLE_BITS-1:0]),
    .chunk_start (in_tuser[USER_START_BIT]),
    .chunk_len   (in_tdata[SAMPLE_BITS+LEN_W-1:SAMPLE_BITS]),
    .chunk_final (in_tuser[USER_FINAL_BIT]),
    .job_sample  (f_sample),
    .job         (f_job)
  );

  acfs_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({f_job, f_sample}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign b_sample = q_out[SAMPLE_BITS-1:0];
  assign b_job    = q_out[Q_W-1:SAMPLE_BITS];

  acfs_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_sample   (b_sample),
    .q_job      (b_job),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_zrun   (out_zrun)
  );

  assign out_tdata = OUT_DW'({out_zrun, out_sample});

endmodule

### src/acfs_checker.sv
// ----------------------------------------------------------------------------
// acfs_checker: port-level checks for the fade splicer
// Tracks items in flight from the handshakes and checks output behavior.
// ----------------------------------------------------------------------------
module acfs_checker import acfs_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [((SAMPLE_BITS+LEN_W+7)/8)*8-1:0]  in_tdata,
  input logic [USER_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [((SAMPLE_BITS+ZRUN_W+7)/8)*8-1:0] out_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CAP    = QUEUE_DEPTH + 2;
  localparam int PEND_W = $clog2(CAP + 2);

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + PEND_W'(1);
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - PEND_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != '0)
    else $error("result offered with no item in flight");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(CAP))
    else $error("more items in flight than the design can hold");

endmodule

bind audio_chunk_fade_splicer_top acfs_checker #(
  .MAX_CHANNELS (MAX_CHANNELS),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_acfs_checker (.*);

### bench/tb_audio_chunk_fade_splicer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_chunk_fade_splicer_top: self-checking bench for the fade splicer
// A short table of directed items is followed by random chunk streams under
// a range of fade_len / chan_count settings. Every accepted result is checked
// against the table or an in-bench model of splice weights and zero runs.
// ----------------------------------------------------------------------------
module tb_audio_chunk_fade_splicer_top;
  import acfs_pkg::*;

  localparam int IN_W  = ((SAMPLE_BITS_DEF + LEN_W + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS_DEF + ZRUN_W + 7) / 8) * 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 30;
  localparam int MAX_REPORTS = 50;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [ZRUN_W-1:0] zrun;
    logic [15:0]       sample;
  } spliced_t;

  typedef enum logic {RK_ITEM, RK_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          sample;
    logic                 start;
    logic [15:0]          len;    // cfg data on RK_CFG rows
    logic                 fin;
    logic                 typed;
    logic [15:0]          exp_sample;
    logic [ZRUN_W-1:0]    exp_zrun;
  } dir_row_t;

  localparam int DIR_N = 21;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic [USER_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  audio_chunk_fade_splicer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // splice model state
  logic [FADE_W-1:0] fade_cfg = '0;
  logic [CHAN_W-1:0] chan_cfg = CHAN_W'(1);
  int unsigned sp_frame;
  int unsigned sp_chan;
  int unsigned sp_len;
  logic        sp_final;
  logic        sp_new_stream = 1'b1;  // next chunk opens a stream
  logic        sp_opens      = 1'b1;  // current chunk opens its stream

  spliced_t spliced_q[$];
  dir_row_t dir_rows [DIR_N];

  int  mismatch_count;
  int  items_sent;
  int  chunks_sent;
  int  results_checked;
  int  settings_used;
  bit  burst_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff_chans();
    if (chan_cfg == 0) return 1;
    if (chan_cfg > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
    return chan_cfg;
  endfunction

  function automatic longint fade_weight(int unsigned i, int unsigned n, bit rising);
    longint den;
    longint num;
    if (n <= 1) return rising ? 0 : 65536;
    den = n - 1;
    num = rising ? longint'(i) : den - longint'(i);
    return (num <<< 16) / den;
  endfunction

  function automatic longint fade_apply(longint s, longint w);
    return (s * w) / 65536;
  endfunction

  function automatic spliced_t splice_predict(logic [15:0] smp, logic start,
                                              logic [15:0] len, logic fin);
    longint      s;
    int unsigned ch;
    int unsigned win_in;
    int unsigned win_out;
    spliced_t    r;
    s = longint'($signed(smp));
    ch = eff_chans();
    r.zrun = '0;
    if (start) begin
      sp_opens      = sp_new_stream;
      sp_len        = len;
      sp_final      = fin;
      sp_new_stream = fin;
      sp_frame      = 0;
      sp_chan       = 0;
      if (!sp_opens) r.zrun = ZRUN_W'(fade_cfg * ch);
    end
    if (sp_frame < sp_len) begin
      win_in  = (fade_cfg < sp_len) ? fade_cfg : sp_len;
      win_out = sp_opens ? win_in : fade_cfg;
      // fade-in first, then fade-out, truncating after each
      if (!sp_opens && sp_frame < win_in)
        s = fade_apply(s, fade_weight(sp_frame, win_in, 1'b1));
      if (!sp_final && sp_frame + win_out >= sp_len)
        s = fade_apply(s, fade_weight(sp_frame + win_out - sp_len, win_out, 1'b0));
    end
    if (sp_chan + 1 >= ch) begin
      sp_chan = 0;
      if (sp_frame < 16'hFFFF) sp_frame++;
    end else begin
      sp_chan++;
    end
    r.sample = s[15:0];
    return r;
  endfunction

  task automatic push_sample(logic [15:0] smp, logic start, logic [15:0] len,
                             logic fin, logic typed, spliced_t typed_exp);
    int       gap;
    spliced_t r;
    logic [USER_W-1:0] user;
    gap = burst_on ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    user = '0;
    user[USER_START_BIT] = start;
    user[USER_FINAL_BIT] = fin;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({len, smp});
    in_tuser  <= user;
    do @(posedge clk); while (!in_tready);
    r = splice_predict(smp, start, len, fin);
    spliced_q.insert(spliced_q.size(), typed ? typed_exp : r);
    items_sent++;
    if (start) chunks_sent++;
  endtask

  // lower valid and let every outstanding item come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (spliced_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FADE_LEN) fade_cfg = data[FADE_W-1:0];
    else if (idx == REG_CHAN_COUNT) chan_cfg = data[CHAN_W-1:0];
    @(posedge clk);
  endtask

  // result side
  initial begin
    spliced_t exp_r;
    logic [15:0]       got_s;
    logic [ZRUN_W-1:0] got_z;
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = burst_on ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_s = out_tdata[15:0];
      got_z = out_tdata[16 +: ZRUN_W];
      results_checked++;
      if (spliced_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none, got sample %h zero_run %0d",
                   $time, got_s, got_z);
      end else begin
        exp_r = spliced_q.pop_front();
        if (got_s !== exp_r.sample) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: sample_out mismatch, expected %h, actual %h",
                     $time, exp_r.sample, got_s);
        end
        if (got_z !== exp_r.zrun) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: zero_run mismatch, expected %0d, actual %0d",
                     $time, exp_r.zrun, got_z);
        end
      end
    end
  end

  // stimulus
  initial begin
    int          phase_items;
    int          pick;
    int          n;
    int unsigned ch;
    bit          drained;
    logic [15:0] len;
    logic        fin;
    logic [15:0] smp;
    logic [FADE_W-1:0] fade_set [PHASES];
    logic [CHAN_W-1:0] chan_set [PHASES];

    fade_set = '{12'd1, 12'd3, 12'd4095, 12'd5, 12'd2, 12'd0, 12'd7, 12'd4095,
                 12'd1, 12'd0};
    chan_set = '{4'd1, 4'd2, 4'd8, 4'd15, 4'd0, 4'd3, 4'd5, 4'd1, 4'd8, 4'd0};
    fade_set[PHASES-1] = FADE_W'($urandom_range(0, 4095));
    chan_set[PHASES-1] = CHAN_W'($urandom_range(0, 15));

    // kind idx sample start len fin typed exp_sample exp_zrun
    dir_rows = '{
      // reset settings: everything passes through
      '{RK_ITEM, REG_FADE_LEN, 16'h7FFF, 1'b0, 16'h0000, 1'b0, 1'b1, 16'h7FFF, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h8000, 1'b0, 16'hFFFF, 1'b1, 1'b1, 16'h8000, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h0001, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'h0001, 15'd0},
      '{RK_CFG,  REG_FADE_LEN,   16'h0, 1'b0, 16'd2, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_CFG,  REG_CHAN_COUNT, 16'h0, 1'b0, 16'd2, 1'b0, 1'b0, 16'h0, 15'd0},
      // stream opener, fade-out only
      '{RK_ITEM, REG_FADE_LEN, 16'h7FFF, 1'b1, 16'd2, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h8000, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h4E20, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'hB1E0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      // final chunk: silence before it, fade-in starts muted
      '{RK_ITEM, REG_FADE_LEN, 16'h7FFF, 1'b1, 16'd2, 1'b1, 1'b1, 16'h0000, 15'd4},
      '{RK_ITEM, REG_FADE_LEN, 16'h8000, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h1234, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'hEDCC, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      // past the declared length
      '{RK_ITEM, REG_FADE_LEN, 16'h5555, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      // restart after final: one-frame window passes
      '{RK_ITEM, REG_FADE_LEN, 16'h04D2, 1'b1, 16'd1, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'hFB2E, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      // one-frame fade-in mutes, then a start mid-frame
      '{RK_ITEM, REG_FADE_LEN, 16'h7530, 1'b1, 16'd1, 1'b0, 1'b1, 16'h0000, 15'd4},
      '{RK_ITEM, REG_FADE_LEN, 16'h7FFF, 1'b1, 16'd3, 1'b1, 1'b1, 16'h0000, 15'd4},
      '{RK_ITEM, REG_FADE_LEN, 16'h8000, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h7FFF, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0},
      '{RK_ITEM, REG_FADE_LEN, 16'h8001, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0, 15'd0}
    };

    burst_on = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RK_CFG) begin
        drain_results();
        cfg_write(dir_rows[i].idx, dir_rows[i].len[CFG_DATA_W-1:0]);
      end else begin
        push_sample(dir_rows[i].sample, dir_rows[i].start, dir_rows[i].len,
                    dir_rows[i].fin, dir_rows[i].typed,
                    '{zrun: dir_rows[i].exp_zrun, sample: dir_rows[i].exp_sample});
      end
    end
    settings_used = 2;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      cfg_write(REG_FADE_LEN, fade_set[p]);
      cfg_write(REG_CHAN_COUNT, {CFG_DATA_W'($urandom_range(0, 255)) << CHAN_W} |
                                CFG_DATA_W'(chan_set[p]));
      if (p % 2 == 1)
        cfg_write((p % 4 == 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(0, 4095)));
      settings_used++;
      ch = eff_chans();
      phase_items = 0;
      drained = 1'b0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        burst_on = ($urandom_range(0, 3) == 0);
        if (pick < 8) begin
          // stray items outside any chunk framing
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++)
            push_sample(16'($urandom), 1'b0, 16'($urandom), 1'($urandom), 1'b0, '0);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 12));
          fin = ($urandom_range(0, 3) == 0);
          n = (len > 12) ? $urandom_range(1, 20) : int'(len) * int'(ch);
          if (pick < 16) n = $urandom_range(1, n);
          else if (pick < 24) n += $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
              0: smp = 16'h7FFF;
              1: smp = 16'h8000;
              default: smp = 16'($urandom);
            endcase
            // header fields on non-start items must be ignored
            if (k == 0) push_sample(smp, 1'b1, len, fin, 1'b0, '0);
            else push_sample(smp, 1'b0, 16'($urandom), 1'($urandom), 1'b0, '0);
          end
          phase_items += n;
        end
        if (pick < 8) phase_items += n;
        if (!drained && phase_items > PHASE_ITEMS / 2) begin
          drained = 1'b1;
          drain_results();
        end
      end
    end

    burst_on = 1'b0;
    drain_results();
    $display("Covered %0d items in %0d chunks over %0d register settings;",
             items_sent, chunks_sent, settings_used);
    $display("%0d results checked, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && spliced_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### audio_chunk_fade_splicer_top.f
src/acfs_pkg.sv
src/acfs_front.sv
src/acfs_queue.sv
src/acfs_back.sv
src/audio_chunk_fade_splicer_top.sv
src/acfs_checker.sv
bench/tb_audio_chunk_fade_splicer_top.sv
